// ===== rtl/core/pidr_pkg.sv =====
`default_nettype none

package pidr_pkg;

  // per-motor state word kept in the state memory
  typedef struct packed {
    logic signed [24:0] integ;
    logic signed [17:0] prev;
  } pidr_entry_t;

  // stage load strobes for one divide-by-1000 lane
  typedef struct packed {
    logic ld_x;
    logic ld_q0;
    logic ld_q;
  } pidr_ld_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WLIM   = 3'd4;

  localparam logic signed [16:0] DEADBAND = 17'sd1000;
  localparam logic [15:0]        MAG_MAX  = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/pidr_if.sv =====
`default_nettype none

interface pidr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  motor_index;
  logic [15:0] position_target;
  logic [15:0] position_measured;

  modport source (output valid, output motor_index, output position_target,
                  output position_measured, input ready);
  modport sink (input valid, input motor_index, input position_target,
                input position_measured, output ready);
endinterface

interface pidr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_magnitude;
  logic        drive_negative;

  modport source (output valid, output drive_magnitude, output drive_negative,
                  input ready);
  modport sink (input valid, input drive_magnitude, input drive_negative,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pidr_state_mem.sv =====
`default_nettype none

module pidr_state_mem import pidr_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire pidr_entry_t   wr_data,
  output pidr_entry_t        rd_data
);

  pidr_entry_t      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  pidr_entry_t      rdata_r;
  logic             rvalid_r;
  logic             fwd_r;
  pidr_entry_t      fwd_data_r;
  logic             fwd_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // a write at the same edge as the read is not seen by the array read
  assign fwd_nxt = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
        fwd_r    <= fwd_nxt;
      end
    end
  end

  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (rvalid_r) begin
      rd_data = rdata_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pidr_div1000.sv =====
`default_nettype none

module pidr_div1000 import pidr_pkg::*; (
  input  wire logic               clk,
  input  wire pidr_ld_t           ld,
  input  wire logic signed [41:0] prod,
  output logic [25:0]             quot,
  output logic                    neg
);

  // x/1000 = (x/8)/125, reciprocal floor(2^38/125) is short by at most one
  localparam logic [31:0] Recip      = 32'd2199023255;
  localparam int          RecipShift = 38;
  localparam logic [32:0] DivRest    = 33'd125;

  logic [41:0] mag;
  logic [37:0] shifted;
  logic [31:0] x_nxt;
  logic [31:0] x_r;
  logic        neg_x_r;

  logic [63:0] q0_full;
  logic [25:0] q0_r;
  logic [31:0] x_q0_r;
  logic        neg_q0_r;

  logic [32:0] q0_times;
  logic [32:0] rem;
  logic [25:0] q_nxt;
  logic [25:0] quot_r;
  logic        neg_q_r;

  always_comb begin
    mag     = prod[41] ? 42'(-prod) : 42'(prod);
    shifted = mag[40:3];
    // a clamped quotient is far beyond any drive that can still be cancelled
    x_nxt   = (|shifted[37:32]) ? '1 : shifted[31:0];
  end

  always_ff @(posedge clk) begin
    if (ld.ld_x) begin
      x_r     <= x_nxt;
      neg_x_r <= prod[41];
    end
  end

  assign q0_full = x_r * Recip;

  always_ff @(posedge clk) begin
    if (ld.ld_q0) begin
      q0_r     <= q0_full[RecipShift +: 26];
      x_q0_r   <= x_r;
      neg_q0_r <= neg_x_r;
    end
  end

  always_comb begin
    q0_times = 33'({q0_r, 7'b0}) - 33'({q0_r, 1'b0}) - 33'(q0_r);
    rem      = 33'(x_q0_r) - q0_times;
    q_nxt    = (rem >= DivRest) ? q0_r + 26'd1 : q0_r;
  end

  always_ff @(posedge clk) begin
    if (ld.ld_q) begin
      quot_r  <= q_nxt;
      neg_q_r <= neg_q0_r;
    end
  end

  assign quot = quot_r;
  assign neg  = neg_q_r;

endmodule

`default_nettype wire

// ===== rtl/core/pid_position_regulator.sv =====
// channel   dir  handshake          payload
// in_ch     in   valid/ready        motor_index, position_target, position_measured
// out_ch    out  valid/ready        drive_magnitude, drive_negative
// cfg       in   cfg_wr_en strobe   cfg_index, cfg_data
//
// seven-stage pipeline, one request per cycle while out_ch is not stalled
// per-motor state sits in a registered-read memory, read-modify-write in stage 1
// with forwarding when back-to-back requests hit the same motor
// reset clears the config registers, the stage valid bits and the state valid bits
// a stalled output fills the stages behind it one by one before in_ch.ready drops
`default_nettype none

module pid_position_regulator import pidr_pkg::*; #(
  parameter int MOTORS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  pidr_in_if.sink                  in_ch,
  pidr_out_if.source               out_ch,
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int AW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int NSTG = 7;

  // configuration
  logic        mode_r;
  logic [15:0] gain_p_r;
  logic [15:0] gain_i_r;
  logic [15:0] gain_d_r;
  logic [23:0] wlim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      wlim_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_GAIN_P: gain_p_r <= cfg_data[15:0];
        CFG_GAIN_I: gain_i_r <= cfg_data[15:0];
        CFG_GAIN_D: gain_d_r <= cfg_data[15:0];
        CFG_WLIM:   wlim_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld[0]      = in_ch.valid && rdy[0];
    vld_nxt[0] = rdy[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      ld[k]      = vld_r[k-1] && rdy[k];
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = rdy[0];

  // stage 0: capture request, issue state read
  logic [AW+2:0] idx_ext;
  logic [AW-1:0] in_addr;
  logic          in_act;
  logic          s0_act_r;
  logic [AW-1:0] s0_addr_r;
  logic [15:0]   s0_tgt_r;
  logic [15:0]   s0_meas_r;

  assign idx_ext = {AW'(0), in_ch.motor_index};
  assign in_addr = idx_ext[AW-1:0];
  assign in_act  = mode_r && (32'(in_ch.motor_index) < MOTORS);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_act_r  <= in_act;
      s0_addr_r <= in_addr;
      s0_tgt_r  <= in_ch.position_target;
      s0_meas_r <= in_ch.position_measured;
    end
  end

  pidr_entry_t mem_rd;
  pidr_entry_t mem_wr;
  logic        mem_we;

  pidr_state_mem #(
    .DEPTH (MOTORS),
    .AW    (AW)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ld[0]),
    .rd_addr (in_addr),
    .wr_en   (mem_we),
    .wr_addr (s0_addr_r),
    .wr_data (mem_wr),
    .rd_data (mem_rd)
  );

  // stage 1 entry: deadband, integral update with anti-windup
  logic signed [16:0] e_raw;
  logic signed [16:0] e_dz;
  logic               dead;
  logic signed [24:0] i_base;
  logic signed [25:0] i_sum;
  logic signed [25:0] lim_s;
  logic signed [24:0] i_new;
  logic signed [18:0] d_full;

  always_comb begin
    e_raw  = $signed({1'b0, s0_tgt_r}) - $signed({1'b0, s0_meas_r});
    dead   = (e_raw >= -DEADBAND) && (e_raw <= DEADBAND);
    e_dz   = dead ? '0 : e_raw;
    i_base = dead ? '0 : mem_rd.integ;
    i_sum  = 26'(i_base) + 26'(e_dz);
    lim_s  = $signed({2'b00, wlim_r});
    i_new  = (i_sum > lim_s || i_sum < -lim_s) ? i_base : i_sum[24:0];
    d_full = 19'(e_dz) - 19'(mem_rd.prev);
    mem_wr.integ = i_new;
    mem_wr.prev  = 18'(e_dz);
  end

  assign mem_we = ld[1] && s0_act_r;

  logic               s1_act_r;
  logic signed [16:0] s1_e_r;
  logic signed [24:0] s1_i_r;
  logic signed [17:0] s1_d_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_act_r <= s0_act_r;
      s1_e_r   <= e_dz;
      s1_i_r   <= i_new;
      s1_d_r   <= d_full[17:0];
    end
  end

  // stage 2: gain products
  logic signed [33:0] pp;
  logic signed [41:0] pi;
  logic signed [34:0] pd;

  always_comb begin
    pp = $signed({1'b0, gain_p_r}) * s1_e_r;
    pi = $signed({1'b0, gain_i_r}) * s1_i_r;
    pd = $signed({1'b0, gain_d_r}) * s1_d_r;
  end

  logic               s2_act_r;
  logic signed [41:0] s2_pp_r;
  logic signed [41:0] s2_pi_r;
  logic signed [41:0] s2_pd_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_act_r <= s1_act_r;
      s2_pp_r  <= 42'(pp);
      s2_pi_r  <= pi;
      s2_pd_r  <= 42'(pd);
    end
  end

  // stages 3 to 5: truncating divide by 1000 per term
  pidr_ld_t    lane_ld;
  logic [25:0] q_p;
  logic [25:0] q_i;
  logic [25:0] q_d;
  logic        n_p;
  logic        n_i;
  logic        n_d;

  assign lane_ld.ld_x  = ld[3];
  assign lane_ld.ld_q0 = ld[4];
  assign lane_ld.ld_q  = ld[5];

  pidr_div1000 u_div_p (.clk(clk), .ld(lane_ld), .prod(s2_pp_r), .quot(q_p), .neg(n_p));
  pidr_div1000 u_div_i (.clk(clk), .ld(lane_ld), .prod(s2_pi_r), .quot(q_i), .neg(n_i));
  pidr_div1000 u_div_d (.clk(clk), .ld(lane_ld), .prod(s2_pd_r), .quot(q_d), .neg(n_d));

  logic s3_act_r;
  logic s4_act_r;
  logic s5_act_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_act_r <= s2_act_r;
    end
    if (ld[4]) begin
      s4_act_r <= s3_act_r;
    end
    if (ld[5]) begin
      s5_act_r <= s4_act_r;
    end
  end

  // stage 6: sum, direction, saturation
  logic signed [27:0] t_p;
  logic signed [27:0] t_i;
  logic signed [27:0] t_d;
  logic signed [27:0] sum;
  logic        [27:0] sum_mag;
  logic        [15:0] mag_nxt;
  logic               neg_nxt;

  always_comb begin
    t_p     = n_p ? -$signed({2'b00, q_p}) : $signed({2'b00, q_p});
    t_i     = n_i ? -$signed({2'b00, q_i}) : $signed({2'b00, q_i});
    t_d     = n_d ? -$signed({2'b00, q_d}) : $signed({2'b00, q_d});
    sum     = t_p + t_i + t_d;
    sum_mag = sum[27] ? 28'(-sum) : 28'(sum);
    if (!s5_act_r) begin
      mag_nxt = '0;
      neg_nxt = 1'b0;
    end else begin
      mag_nxt = (|sum_mag[27:16]) ? MAG_MAX : sum_mag[15:0];
      neg_nxt = sum[27];
    end
  end

  logic [15:0] out_mag_r;
  logic        out_neg_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      out_mag_r <= mag_nxt;
      out_neg_r <= neg_nxt;
    end
  end

  assign out_ch.valid           = vld_r[NSTG-1];
  assign out_ch.drive_magnitude = out_mag_r;
  assign out_ch.drive_negative  = out_neg_r;

endmodule

`default_nettype wire

// ===== rtl/core/pidr_checker.sv =====
`default_nettype none

module pidr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] drive_magnitude,
  input wire logic        drive_negative
);

  logic [3:0] pend_r;
  logic [3:0] pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready) begin
      pend_nxt = pend_nxt + 4'd1;
    end
    if (out_valid && out_ready) begin
      pend_nxt = pend_nxt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // no result without a request in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result shown with no request in flight");

  // empty pipeline never refuses a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 4'd0 |-> in_ready)
    else $error("empty block not ready");

  // negative direction only with a nonzero drive
  a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drive_negative |-> drive_magnitude != 16'd0)
    else $error("negative direction with zero drive");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive_magnitude)
      && $stable(drive_negative))
    else $error("stalled result changed");

endmodule

bind pid_position_regulator pidr_checker u_pidr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .drive_magnitude (out_ch.drive_magnitude),
  .drive_negative  (out_ch.drive_negative)
);

`default_nettype wire
